// File: rtl/mackey_glass_euler_step_core_defines.svh
// Assertion macros for the Mackey-Glass Euler step core checker.
`ifndef MACKEY_GLASS_EULER_STEP_CORE_DEFINES_SVH
`define MACKEY_GLASS_EULER_STEP_CORE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define MGE_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define MGE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mge_pkg.sv
// Shared types, constants and fixed-point helpers for the Mackey-Glass Euler step core.
`timescale 1ns / 1ps

package mge_pkg;

	localparam int FRAC_BITS         = 24;
	localparam int HISTORY_DEPTH_DEF = 1024;
	localparam int VAL_W             = 32;
	localparam int COEF_W            = 31;
	localparam int EXP_W             = 5;
	localparam int LEN_CFG_W         = 11;
	localparam int CFG_IDX_W         = 3;
	localparam int PROD_W            = 64;
	localparam int POW_W             = 63;
	localparam int Q_BITS            = 33;

	localparam logic [PROD_W-1:0] ONE_FIX = 64'd1 << FRAC_BITS;
	localparam logic [POW_W-1:0]  POW_CAP = 63'd1 << 62;

	localparam logic [COEF_W-1:0] STEP_SIZE_RST = COEF_W'((ONE_FIX * 64'd10 + 64'd50) / 64'd100);
	localparam logic [COEF_W-1:0] GAIN_RST      = COEF_W'((ONE_FIX * 64'd20 + 64'd50) / 64'd100);
	localparam logic [COEF_W-1:0] DECAY_RST     = COEF_W'((ONE_FIX * 64'd10 + 64'd50) / 64'd100);
	localparam logic [EXP_W-1:0]     HILL_RST  = 5'd10;
	localparam logic [LEN_CFG_W-1:0] DELAY_RST = 11'd170;
	localparam logic [VAL_W-1:0]     CUR_RST   = VAL_W'((ONE_FIX + 64'd50) / 64'd100);

	localparam logic REQ_PRELOAD = 1'b0;
	localparam logic REQ_STEP    = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_STEP_SIZE       = 3'd0,
		CFG_PRODUCTION_GAIN = 3'd1,
		CFG_DECAY_RATE      = 3'd2,
		CFG_HILL_EXPONENT   = 3'd3,
		CFG_DELAY_LENGTH    = 3'd4
	} cfg_index_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_PLO,
		ST_PHI,
		ST_PACC,
		ST_NUM,
		ST_NUMW,
		ST_DIV,
		ST_DERIV,
		ST_UPD,
		ST_UPDW,
		ST_WB
	} state_t;

	typedef struct packed {
		logic                    req_type;
		logic signed [VAL_W-1:0] history_value;
	} req_t;

	typedef struct packed {
		logic signed [VAL_W-1:0] new_value;
		logic signed [VAL_W-1:0] delayed_value;
	} result_t;

	typedef struct packed {
		logic busy;
		logic ovf;
	} div_stat_t;

	function automatic logic [VAL_W-1:0] mag32(input logic signed [VAL_W-1:0] v);
		logic [VAL_W-1:0] u;
		u = v;
		return u[VAL_W-1] ? (~u + 32'd1) : u;
	endfunction

	function automatic logic signed [VAL_W-1:0] sat_sm(input logic [PROD_W-1:0] mag,
		input logic neg);
		logic [VAL_W-1:0] neg_val;
		neg_val = ~mag[VAL_W-1:0] + 32'd1;
		if (!neg) begin
			return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(mag[VAL_W-1:0]);
		end
		if (mag > 64'h8000_0000) begin
			return 32'sh8000_0000;
		end
		return signed'(neg_val);
	endfunction

	function automatic logic signed [VAL_W-1:0] sat33(input logic signed [VAL_W:0] v);
		if (v[VAL_W] != v[VAL_W-1]) begin
			return v[VAL_W] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return signed'(v[VAL_W-1:0]);
	endfunction

endpackage

// File: rtl/mge_mul.sv
// Shared 32 by 32 unsigned multiplier with a registered product.
`timescale 1ns / 1ps

module mge_mul (
	input  logic                           clk,
	input  logic [mge_pkg::VAL_W-1:0]      a,
	input  logic [mge_pkg::VAL_W-1:0]      b,
	output logic [mge_pkg::PROD_W-1:0]     p
);

	always_ff @(posedge clk) begin
		p <= mge_pkg::PROD_W'(a) * mge_pkg::PROD_W'(b);
	end

endmodule

// File: rtl/mge_div.sv
// Radix-2 restoring divider that yields a saturation flag and the low quotient bits.
`timescale 1ns / 1ps

module mge_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [mge_pkg::PROD_W-1:0]      dividend,
	input  logic [mge_pkg::PROD_W-1:0]      divisor,
	output logic [mge_pkg::Q_BITS-1:0]      quotient,
	output mge_pkg::div_stat_t              stat
);

	localparam int CNT_W = $clog2(mge_pkg::Q_BITS + 1);

	logic                          busy_q;
	logic [CNT_W-1:0]              cnt_q;
	logic [mge_pkg::PROD_W-1:0]    rem_q;
	logic [mge_pkg::PROD_W-1:0]    den_q;
	logic [mge_pkg::Q_BITS-1:0]    bits_q;
	logic [mge_pkg::Q_BITS-1:0]    quo_q;
	logic                          ovf_q;
	logic [mge_pkg::PROD_W:0]      trial;
	logic [mge_pkg::PROD_W:0]      diff;
	logic                          ge;
	logic [mge_pkg::PROD_W-1:0]    top_part;

	assign top_part = dividend >> mge_pkg::Q_BITS;
	assign trial    = {rem_q, bits_q[mge_pkg::Q_BITS-1]};
	assign ge       = trial >= {1'b0, den_q};
	assign diff     = trial - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(mge_pkg::Q_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= top_part;
			den_q  <= divisor;
			bits_q <= dividend[mge_pkg::Q_BITS-1:0];
			quo_q  <= '0;
			ovf_q  <= top_part >= divisor;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[mge_pkg::PROD_W-1:0] : trial[mge_pkg::PROD_W-1:0];
			bits_q <= {bits_q[mge_pkg::Q_BITS-2:0], 1'b0};
			quo_q  <= {quo_q[mge_pkg::Q_BITS-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.ovf  = ovf_q;

endmodule

// File: rtl/mge_ring.sv
// Delay ring memory with one write port and one registered read port.
`timescale 1ns / 1ps

module mge_ring #(
	parameter int DEPTH = mge_pkg::HISTORY_DEPTH_DEF,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [AW-1:0]              waddr,
	input  logic [mge_pkg::VAL_W-1:0]  wdata,
	input  logic                       re,
	input  logic [AW-1:0]              raddr,
	output logic [mge_pkg::VAL_W-1:0]  rdata
);

	logic [mge_pkg::VAL_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/mackey_glass_euler_step_core.sv
// Mackey-Glass delay equation core: one forward Euler step per step beat, Q8.24 fixed point.
// A preload beat is taken while idle and the next beat may follow at once.
// A step beat runs LOAD, then per unit of the exponent the multiplier passes PLO and PHI and
// the accumulate state PACC, then NUM, NUMW, the divider pass in DIV, DERIV, UPD, UPDW and WB,
// which waits until the output is free; the next beat is taken once the core is back in IDLE.
// Reset loads the register defaults, the state value 0.01 and pointer zero; the ring is not cleared.
`timescale 1ns / 1ps

module mackey_glass_euler_step_core #(
	parameter int HISTORY_DEPTH = mge_pkg::HISTORY_DEPTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_write,
	input  logic [mge_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mge_pkg::COEF_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  mge_pkg::req_t                      in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output mge_pkg::result_t                   out_data
);

	localparam int PTR_W = $clog2(HISTORY_DEPTH);
	localparam int LEN_W = ($clog2(HISTORY_DEPTH + 1) > mge_pkg::LEN_CFG_W) ?
		$clog2(HISTORY_DEPTH + 1) : mge_pkg::LEN_CFG_W;

	mge_pkg::state_t state_q, state_d;

	logic [mge_pkg::COEF_W-1:0]    step_size_q;
	logic [mge_pkg::COEF_W-1:0]    gain_q;
	logic [mge_pkg::COEF_W-1:0]    decay_q;
	logic [mge_pkg::EXP_W-1:0]     hill_q;
	logic [mge_pkg::LEN_CFG_W-1:0] delay_len_q;

	logic [PTR_W-1:0]                 ptr_q;
	logic signed [mge_pkg::VAL_W-1:0] cur_q;
	logic [mge_pkg::EXP_W-1:0]        pcnt_q;
	logic                             out_valid_q;
	mge_pkg::result_t                 out_q;

	logic signed [mge_pkg::VAL_W-1:0] x_q;
	logic [mge_pkg::VAL_W-1:0]        ax_q;
	logic [mge_pkg::POW_W-1:0]        pmag_q;
	logic [mge_pkg::PROD_W-1:0]       lo_q;
	logic [mge_pkg::PROD_W-1:0]       dmag_q;
	logic                             den_neg_q;
	logic                             den_zero_q;
	logic                             num_zero_q;
	logic signed [mge_pkg::VAL_W-1:0] deriv_q;
	logic signed [mge_pkg::VAL_W-1:0] newp_q;

	logic                       in_fire;
	logic                       is_step;
	logic                       out_free;
	logic [LEN_W-1:0]           len_ext;
	logic [LEN_W-1:0]           eff_len;
	logic [LEN_W-1:0]           ptr_sum;
	logic [PTR_W-1:0]           ptr_adv;

	logic [mge_pkg::VAL_W-1:0]  mul_a;
	logic [mge_pkg::VAL_W-1:0]  mul_b;
	logic [mge_pkg::PROD_W-1:0] mul_p;

	logic                       div_start;
	logic [mge_pkg::Q_BITS-1:0] div_quo;
	mge_pkg::div_stat_t         div_stat;

	logic                       ring_we;
	logic [PTR_W-1:0]           ring_waddr;
	logic [mge_pkg::VAL_W-1:0]  ring_wdata;
	logic                       ring_re;
	logic [mge_pkg::VAL_W-1:0]  ring_rdata;

	logic [mge_pkg::PROD_W:0]   hi_sum;
	logic [mge_pkg::PROD_W-1:0] low64;
	logic [mge_pkg::PROD_W-1:0] pow_shift;
	logic [mge_pkg::POW_W-1:0]  pow_next;

	logic [mge_pkg::PROD_W-1:0] pmag64;
	logic                       pneg;
	logic [mge_pkg::PROD_W-1:0] dmag_val;
	logic                       den_neg_val;

	logic                             q_sign;
	logic signed [mge_pkg::VAL_W-1:0] q_val;
	logic signed [mge_pkg::VAL_W-1:0] gp_val;
	logic signed [mge_pkg::VAL_W-1:0] upd_val;
	logic signed [mge_pkg::VAL_W:0]   deriv_sum;
	logic signed [mge_pkg::VAL_W:0]   newp_sum;
	logic signed [mge_pkg::VAL_W-1:0] deriv_val;
	logic signed [mge_pkg::VAL_W-1:0] newp_val;

	assign in_fire  = in_valid && in_ready;
	assign is_step  = in_data.req_type == mge_pkg::REQ_STEP;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		len_ext = LEN_W'(delay_len_q);
		if (len_ext == '0) begin
			eff_len = LEN_W'(1);
		end else if (len_ext > LEN_W'(HISTORY_DEPTH)) begin
			eff_len = LEN_W'(HISTORY_DEPTH);
		end else begin
			eff_len = len_ext;
		end
		ptr_sum = LEN_W'(ptr_q) + LEN_W'(1);
		ptr_adv = (ptr_sum >= eff_len) ? '0 : ptr_sum[PTR_W-1:0];
	end

	always_comb begin
		hi_sum    = {1'b0, mul_p} + {33'd0, lo_q[63:32]};
		low64     = {hi_sum[31:0], lo_q[31:0]};
		pow_shift = low64 >> mge_pkg::FRAC_BITS;
		if (|hi_sum[64:32]) begin
			pow_next = mge_pkg::POW_CAP;
		end else if (pow_shift > {1'b0, mge_pkg::POW_CAP}) begin
			pow_next = mge_pkg::POW_CAP;
		end else begin
			pow_next = pow_shift[mge_pkg::POW_W-1:0];
		end
	end

	always_comb begin
		pmag64 = {1'b0, pmag_q};
		pneg   = x_q[mge_pkg::VAL_W-1] && hill_q[0];
		if (!pneg) begin
			dmag_val    = pmag64 + mge_pkg::ONE_FIX;
			den_neg_val = 1'b0;
		end else if (pmag64 > mge_pkg::ONE_FIX) begin
			dmag_val    = pmag64 - mge_pkg::ONE_FIX;
			den_neg_val = 1'b1;
		end else begin
			dmag_val    = mge_pkg::ONE_FIX - pmag64;
			den_neg_val = 1'b0;
		end
	end

	always_comb begin
		q_sign = x_q[mge_pkg::VAL_W-1] ^ den_neg_q;
		if (den_zero_q) begin
			q_val = num_zero_q ? '0 : mge_pkg::sat_sm('1, x_q[mge_pkg::VAL_W-1]);
		end else begin
			q_val = mge_pkg::sat_sm(div_stat.ovf ? '1 : mge_pkg::PROD_W'(div_quo), q_sign);
		end
		gp_val    = mge_pkg::sat_sm(mul_p >> mge_pkg::FRAC_BITS, cur_q[mge_pkg::VAL_W-1]);
		deriv_sum = {q_val[mge_pkg::VAL_W-1], q_val} - {gp_val[mge_pkg::VAL_W-1], gp_val};
		deriv_val = mge_pkg::sat33(deriv_sum);
		upd_val   = mge_pkg::sat_sm(mul_p >> mge_pkg::FRAC_BITS, deriv_q[mge_pkg::VAL_W-1]);
		newp_sum  = {cur_q[mge_pkg::VAL_W-1], cur_q} + {upd_val[mge_pkg::VAL_W-1], upd_val};
		newp_val  = mge_pkg::sat33(newp_sum);
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mge_pkg::ST_IDLE: begin
				if (in_fire && is_step) begin
					state_d = mge_pkg::ST_LOAD;
				end
			end
			mge_pkg::ST_LOAD: begin
				state_d = (hill_q == '0) ? mge_pkg::ST_NUM : mge_pkg::ST_PLO;
			end
			mge_pkg::ST_PLO:  state_d = mge_pkg::ST_PHI;
			mge_pkg::ST_PHI:  state_d = mge_pkg::ST_PACC;
			mge_pkg::ST_PACC: begin
				state_d = (pcnt_q == mge_pkg::EXP_W'(1)) ? mge_pkg::ST_NUM : mge_pkg::ST_PLO;
			end
			mge_pkg::ST_NUM:  state_d = mge_pkg::ST_NUMW;
			mge_pkg::ST_NUMW: state_d = mge_pkg::ST_DIV;
			mge_pkg::ST_DIV: begin
				if (!div_stat.busy) begin
					state_d = mge_pkg::ST_DERIV;
				end
			end
			mge_pkg::ST_DERIV: state_d = mge_pkg::ST_UPD;
			mge_pkg::ST_UPD:   state_d = mge_pkg::ST_UPDW;
			mge_pkg::ST_UPDW:  state_d = mge_pkg::ST_WB;
			mge_pkg::ST_WB: begin
				if (out_free) begin
					state_d = mge_pkg::ST_IDLE;
				end
			end
			default: state_d = mge_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		mul_a      = '0;
		mul_b      = '0;
		div_start  = 1'b0;
		ring_we    = 1'b0;
		ring_waddr = ptr_q;
		ring_wdata = in_data.history_value;
		ring_re    = 1'b0;
		unique case (state_q)
			mge_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				ring_re  = in_fire && is_step;
				ring_we  = in_fire && !is_step;
			end
			mge_pkg::ST_PLO: begin
				mul_a = pmag_q[31:0];
				mul_b = ax_q;
			end
			mge_pkg::ST_PHI: begin
				mul_a = {1'b0, pmag_q[62:32]};
				mul_b = ax_q;
			end
			mge_pkg::ST_NUM: begin
				mul_a = {1'b0, gain_q};
				mul_b = ax_q;
			end
			mge_pkg::ST_NUMW: begin
				div_start = 1'b1;
				mul_a     = {1'b0, decay_q};
				mul_b     = mge_pkg::mag32(cur_q);
			end
			mge_pkg::ST_DIV: begin
				mul_a = {1'b0, decay_q};
				mul_b = mge_pkg::mag32(cur_q);
			end
			mge_pkg::ST_UPD: begin
				mul_a = {1'b0, step_size_q};
				mul_b = mge_pkg::mag32(deriv_q);
			end
			mge_pkg::ST_WB: begin
				ring_we    = out_free;
				ring_wdata = newp_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mge_pkg::ST_IDLE;
			step_size_q <= mge_pkg::STEP_SIZE_RST;
			gain_q      <= mge_pkg::GAIN_RST;
			decay_q     <= mge_pkg::DECAY_RST;
			hill_q      <= mge_pkg::HILL_RST;
			delay_len_q <= mge_pkg::DELAY_RST;
			ptr_q       <= '0;
			cur_q       <= signed'(mge_pkg::CUR_RST);
			pcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_write) begin
				unique case (mge_pkg::cfg_index_t'(cfg_index))
					mge_pkg::CFG_STEP_SIZE:       step_size_q <= cfg_data;
					mge_pkg::CFG_PRODUCTION_GAIN: gain_q      <= cfg_data;
					mge_pkg::CFG_DECAY_RATE:      decay_q     <= cfg_data;
					mge_pkg::CFG_HILL_EXPONENT:   hill_q      <= cfg_data[mge_pkg::EXP_W-1:0];
					mge_pkg::CFG_DELAY_LENGTH:    delay_len_q <= cfg_data[mge_pkg::LEN_CFG_W-1:0];
					default: begin
					end
				endcase
			end
			if (in_fire) begin
				ptr_q <= ptr_adv;
			end
			if (state_q == mge_pkg::ST_LOAD) begin
				pcnt_q <= hill_q;
			end else if (state_q == mge_pkg::ST_PACC) begin
				pcnt_q <= pcnt_q - mge_pkg::EXP_W'(1);
			end
			if (state_q == mge_pkg::ST_WB && out_free) begin
				cur_q       <= newp_q;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mge_pkg::ST_LOAD: begin
				x_q    <= signed'(ring_rdata);
				ax_q   <= mge_pkg::mag32(signed'(ring_rdata));
				pmag_q <= mge_pkg::ONE_FIX[mge_pkg::POW_W-1:0];
			end
			mge_pkg::ST_PHI:  lo_q   <= mul_p;
			mge_pkg::ST_PACC: pmag_q <= pow_next;
			mge_pkg::ST_NUM: begin
				dmag_q     <= dmag_val;
				den_neg_q  <= den_neg_val;
				den_zero_q <= dmag_val == '0;
			end
			mge_pkg::ST_NUMW:  num_zero_q <= mul_p == '0;
			mge_pkg::ST_DERIV: deriv_q    <= deriv_val;
			mge_pkg::ST_UPDW:  newp_q     <= newp_val;
			mge_pkg::ST_WB: begin
				if (out_free) begin
					out_q.new_value     <= newp_q;
					out_q.delayed_value <= x_q;
				end
			end
			default: begin
			end
		endcase
	end

	mge_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (mul_p)
	);

	mge_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_p),
		.divisor  (dmag_q),
		.quotient (div_quo),
		.stat     (div_stat)
	);

	mge_ring #(
		.DEPTH (HISTORY_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ring_we),
		.waddr (ring_waddr),
		.wdata (ring_wdata),
		.re    (ring_re),
		.raddr (ptr_adv),
		.rdata (ring_rdata)
	);

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: rtl/mge_checker.sv
// Port-level checker for the Mackey-Glass Euler step core and its bind statement.
`timescale 1ns / 1ps
`include "mackey_glass_euler_step_core_defines.svh"

module mge_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input mge_pkg::req_t    in_data,
	input logic             out_valid,
	input logic             out_ready,
	input mge_pkg::result_t out_data
);

	`MGE_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "Stalled result beat changed.")
	`MGE_ASSERT_NEXT(a_step_busy, in_valid && in_ready && in_data.req_type, !in_ready, "Core took a beat during a step.")
	`MGE_ASSERT_NEXT(a_preload_ready, in_valid && in_ready && !in_data.req_type, in_ready, "Preload beat stalled the input.")
	`MGE_ASSERT_SAME(a_result_from_step, $rose(out_valid), $past(!in_ready), "Result beat appeared without a step in flight.")

endmodule

bind mackey_glass_euler_step_core mge_checker u_mge_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
